FILE: design/rtpseg_pkg.sv
// Shared types and constants of the RTP frame packet segmenter.
`timescale 1ns / 1ps

package rtpseg_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_PAYLOAD_TYPE    = 3'd0;
    localparam logic [2:0] CFG_SOURCE_ID       = 3'd1;
    localparam logic [2:0] CFG_FIRST_PAYLOAD   = 3'd2;
    localparam logic [2:0] CFG_MAX_PAYLOAD     = 3'd3;
    localparam logic [2:0] CFG_DESCRIPTOR_LEN  = 3'd4;
    localparam logic [2:0] CFG_TIMESTAMP_STEP  = 3'd5;
    localparam logic [2:0] CFG_TIMESTAMP_START = 3'd6;

    // Register reset values.
    localparam logic [6:0]  RST_PAYLOAD_TYPE    = 7'd96;
    localparam logic [12:0] RST_FIRST_PAYLOAD   = 13'd256;
    localparam logic [10:0] RST_MAX_PAYLOAD     = 11'd1400;
    localparam logic [6:0]  RST_DESCRIPTOR_LEN  = 7'd0;
    localparam logic [31:0] RST_TIMESTAMP_STEP  = 32'd3000;
    localparam logic [31:0] RST_TIMESTAMP_START = 32'd0;

    // Limits applied to the registers when they are used.
    localparam logic [12:0] FIRST_PAYLOAD_MIN = 13'd1;
    localparam logic [12:0] FIRST_PAYLOAD_MAX = 13'd4096;
    localparam logic [10:0] MAX_PAYLOAD_MIN   = 11'd1000;
    localparam logic [10:0] MAX_PAYLOAD_MAX   = 11'd1472;
    localparam logic [6:0]  DESCRIPTOR_MAX    = 7'd64;
    localparam logic [6:0]  RTP_HEADER_BYTES  = 7'd12;

    localparam int MAX_FRAME_BYTES_DEF = 60000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUILD,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic load;    // capture a frame descriptor and advance the timestamp
        logic build;   // form the next packet descriptor in the output register
    } dp_cmd_t;

    typedef struct packed {
        logic pkt_last;  // the held descriptor is the last of its frame
    } dp_status_t;

endpackage

FILE: design/rtpseg_ctrl.sv
// Controller state machine of the RTP frame packet segmenter.
`timescale 1ns / 1ps

module rtpseg_ctrl
    import rtpseg_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_BUILD;
                end
            end
            ST_BUILD: begin
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (m_tready && status.pkt_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        cmd.load  = 1'b0;
        cmd.build = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_BUILD: begin
                cmd.build = 1'b1;
            end
            ST_SEND: begin
                m_tvalid = 1'b1;
                // The next descriptor replaces the one taken in the same cycle.
                cmd.build = m_tready && !status.pkt_last;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output sides active together");

    a_accept_builds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_BUILD))
        else $error("accepted frame did not start building");

    a_build_sends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BUILD) |=> m_tvalid)
        else $error("built descriptor was not offered");

    a_last_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && status.pkt_last) |=> s_tready)
        else $error("frame end did not return to idle");
`endif

endmodule

FILE: design/rtpseg_dp.sv
// Datapath of the RTP frame packet segmenter: registers, segment arithmetic, descriptors.
`timescale 1ns / 1ps

module rtpseg_dp
    import rtpseg_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic [15:0] s_tdata,
    input  logic        s_tuser,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    output logic [95:0] m_tdata,
    output logic        m_tlast,
    output logic [8:0]  m_tuser
);

    localparam logic [15:0] MaxFrame = 16'(MAX_FRAME_BYTES);

    logic [6:0]  payload_type_reg;
    logic [12:0] first_payload_reg;
    logic [10:0] max_payload_reg;
    logic [6:0]  descriptor_len_reg;
    logic [31:0] ts_step_reg;
    logic [31:0] ts_reg;
    logic [31:0] ts_next;
    logic [15:0] seq_reg;

    logic [15:0] left_reg;
    logic [15:0] offset_reg;
    logic        first_reg;
    logic        key_reg;

    logic [15:0] out_offset_reg;
    logic [12:0] out_len_reg;
    logic [12:0] out_pkt_len_reg;
    logic [15:0] out_seq_reg;
    logic [31:0] out_ts_reg;
    logic        out_first_reg;
    logic        out_last_reg;
    logic        out_key_reg;
    logic [6:0]  out_type_reg;

    logic [12:0] first_len;
    logic [10:0] max_len;
    logic [6:0]  hdr_len;
    logic [15:0] seg_limit;
    logic        seg_last;
    logic [12:0] seg_len;
    logic [15:0] frame_size;

    // Registers are used clamped into their legal ranges.
    always_comb begin
        if (first_payload_reg < FIRST_PAYLOAD_MIN) begin
            first_len = FIRST_PAYLOAD_MIN;
        end else if (first_payload_reg > FIRST_PAYLOAD_MAX) begin
            first_len = FIRST_PAYLOAD_MAX;
        end else begin
            first_len = first_payload_reg;
        end
        if (max_payload_reg < MAX_PAYLOAD_MIN) begin
            max_len = MAX_PAYLOAD_MIN;
        end else if (max_payload_reg > MAX_PAYLOAD_MAX) begin
            max_len = MAX_PAYLOAD_MAX;
        end else begin
            max_len = max_payload_reg;
        end
        if (descriptor_len_reg > DESCRIPTOR_MAX) begin
            hdr_len = RTP_HEADER_BYTES + DESCRIPTOR_MAX;
        end else begin
            hdr_len = RTP_HEADER_BYTES + descriptor_len_reg;
        end
    end

    assign frame_size = (s_tdata > MaxFrame) ? MaxFrame : s_tdata;

    // The first packet is limited by the first payload length, later ones by the maximum.
    assign seg_limit = first_reg ? {3'b000, first_len} : {5'b00000, max_len};
    assign seg_last  = (left_reg <= seg_limit);
    assign seg_len   = seg_last ? left_reg[12:0] : seg_limit[12:0];

    always_comb begin
        ts_next = ts_reg;
        if (cfg_wr_en && cfg_index == CFG_TIMESTAMP_START) begin
            ts_next = cfg_wdata;
        end else if (cmd.load) begin
            ts_next = ts_reg + ts_step_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            payload_type_reg   <= RST_PAYLOAD_TYPE;
            first_payload_reg  <= RST_FIRST_PAYLOAD;
            max_payload_reg    <= RST_MAX_PAYLOAD;
            descriptor_len_reg <= RST_DESCRIPTOR_LEN;
            ts_step_reg        <= RST_TIMESTAMP_STEP;
            ts_reg             <= RST_TIMESTAMP_START;
            seq_reg            <= '0;
        end else begin
            ts_reg <= ts_next;
            if (cmd.build) begin
                seq_reg <= seq_reg + 16'd1;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_PAYLOAD_TYPE:   payload_type_reg   <= cfg_wdata[6:0];
                    // The source identifier is not reported in the descriptors.
                    CFG_SOURCE_ID:      ;
                    CFG_FIRST_PAYLOAD:  first_payload_reg  <= cfg_wdata[12:0];
                    CFG_MAX_PAYLOAD:    max_payload_reg    <= cfg_wdata[10:0];
                    CFG_DESCRIPTOR_LEN: descriptor_len_reg <= cfg_wdata[6:0];
                    CFG_TIMESTAMP_STEP: ts_step_reg        <= cfg_wdata;
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            left_reg   <= frame_size;
            offset_reg <= '0;
            first_reg  <= 1'b1;
            key_reg    <= s_tuser;
        end else if (cmd.build) begin
            left_reg   <= left_reg - {3'b000, seg_len};
            offset_reg <= offset_reg + {3'b000, seg_len};
            first_reg  <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.build) begin
            out_offset_reg  <= offset_reg;
            out_len_reg     <= seg_len;
            out_pkt_len_reg <= seg_len + {6'b000000, hdr_len};
            out_seq_reg     <= seq_reg;
            out_ts_reg      <= ts_reg;
            out_first_reg   <= first_reg;
            out_last_reg    <= seg_last;
            out_key_reg     <= key_reg;
            out_type_reg    <= payload_type_reg;
        end
    end

    assign status.pkt_last = out_last_reg;

    assign m_tdata = {6'b000000, out_ts_reg, out_seq_reg, out_pkt_len_reg,
                      out_len_reg, out_offset_reg};
    assign m_tlast = out_last_reg;
    assign m_tuser = {out_type_reg, out_key_reg, out_first_reg};

endmodule

FILE: design/rtp_frame_packet_segmenter_core.sv
// Top level of the RTP frame packet segmenter: frame descriptors in, packet descriptors out.
//
//   Channel | Direction | tdata (low bit up)                  | tuser / tlast
//   s_      | in        | frame_size[15:0]                    | tuser: key_frame
//   m_      | out       | offset, length, packet length,      | tuser: frame_start,
//           |           | sequence, timestamp (90 of 96 bits) | key_flag, header_type; tlast: marker
//   cfg_    | in        | index 0..6, data up to 32 bits      | write on cfg_wr_en
//
// A frame is taken in the idle state, its first descriptor is formed in the build state,
// and then the block gives one packet descriptor per cycle while m_tready is high, for N
// packets, N from 1 to 61. s_tready is high only between frames. Reset is synchronous and
// active low; no clearing pass. A stalled m_tready holds the current descriptor and the
// frame in progress.
`timescale 1ns / 1ps

module rtp_frame_packet_segmenter_core
    import rtpseg_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // frame_size
    input  logic        s_tuser,   // key_frame
    output logic        m_tvalid,
    input  logic        m_tready,
    // payload_offset, payload_length, packet_length, sequence_number, rtp_timestamp, zero fill
    output logic [95:0] m_tdata,
    output logic        m_tlast,
    output logic [8:0]  m_tuser    // frame_start, key_flag, header_type
);

    dp_cmd_t    cmd;
    dp_status_t status;

    rtpseg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rtpseg_dp #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
